// ===== hw/rtl/sqrt_cross_diag_stencil_core_macros.svh =====
// assertion macros for the stencil core checker
`ifndef SQRT_CROSS_DIAG_STENCIL_CORE_MACROS_SVH
`define SQRT_CROSS_DIAG_STENCIL_CORE_MACROS_SVH

// implication into the next cycle, ignored while in reset
`define SCDS_AST_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("stencil core check failed");

// same-cycle implication, ignored while in reset
`define SCDS_AST_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("stencil core check failed");

// state right after a reset cycle
`define SCDS_AST_RST(lbl, post) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (post)) \
        else $error("stencil core reset check failed");

`endif

// ===== hw/rtl/scds_pkg.sv =====
package scds_pkg;

    localparam int MAX_COLS   = 8192;
    localparam int COL_W      = 13;
    localparam int SIZE_W     = 14;
    localparam int DATA_W     = 32;
    localparam int LANES      = 4;
    localparam int SQ_STEPS   = 25;
    localparam int SUM_W      = 34;
    localparam int RAD_W      = 50;
    localparam int REM_W      = 27;
    localparam int OFFS_W     = 24;

    localparam logic [SIZE_W-1:0] MIN_SIZE   = 14'd5;
    localparam logic [SIZE_W-1:0] MAX_SIZE   = 14'd8192;
    localparam logic [SIZE_W-1:0] RST_SIZE   = 14'd32;

    // offset = (n*131072 + 50) / 100, division by reciprocal multiply
    localparam logic [30:0] OFFS_ROUND = 31'd50;
    localparam logic [31:0] OFFS_RECIP = 32'd2748779070;

    localparam int IN_TDATA_W   = 32;
    localparam int OUT_USED_W   = 2 * COL_W + DATA_W;
    localparam int OUT_TDATA_W  = 64;

    // which result of an item is on the output
    typedef enum logic [1:0] {
        RES_MAIN = 2'd0,
        RES_PREV = 2'd1,
        RES_CUR  = 2'd2
    } t_res;

    // item context carried down the pipeline
    typedef struct packed {
        logic [COL_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              has_main;
        logic              has_final;
        logic              interior;
        logic [DATA_W-1:0] v;
        logic [DATA_W-1:0] pass;
        logic [DATA_W-1:0] prev;
    } t_ctx;

    // one square root step state
    typedef struct packed {
        logic [RAD_W-1:0]    rad;
        logic [REM_W-1:0]    rem;
        logic [SQ_STEPS-1:0] root;
    } t_sq;

endpackage

// ===== hw/rtl/scds_ram.sv =====
module scds_ram #(
    parameter int LANE_W = 32,
    parameter int LANES  = 4,
    parameter int DEPTH  = 8192
) (
    input  logic                          i_clk,
    input  logic [LANES-1:0]              i_we,
    input  logic [$clog2(DEPTH)-1:0]      i_waddr,
    input  logic [LANE_W-1:0]             i_wdata,
    input  logic                          i_re,
    input  logic [$clog2(DEPTH)-1:0]      i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0]      i_raddr_b,
    output logic [LANES*LANE_W-1:0]       o_rdata_a,
    output logic [LANES*LANE_W-1:0]       o_rdata_b
);

    logic [LANES*LANE_W-1:0] mem [DEPTH];

    // lane write, read-first registered reads
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            if (i_we[l]) begin
                mem[i_waddr][l*LANE_W +: LANE_W] <= i_wdata;
            end
        end
        if (i_re) begin
            o_rdata_a <= mem[i_raddr_a];
            o_rdata_b <= mem[i_raddr_b];
        end
    end

endmodule

// ===== hw/rtl/sqrt_cross_diag_stencil_core.sv =====
// path: stage 1, square root stages, tail register, then the output serializer
// throughput: one input item per cycle unless the output stalls; a final-row item
//   gives three results, so final-row items are limited by the single output port
// line store: one 4-lane ram, one write and two reads per item, no clearing pass
// reset: synchronous active low; clears counters, pipeline valids, skid, size to 32
module sqrt_cross_diag_stencil_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [scds_pkg::SIZE_W-1:0]       i_cfg_wr_data,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [31:0] cell_value
    input  logic [scds_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // [0] frame_start
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [12:0] out_row, [25:13] out_col, [57:26] out_value, [63:58] zero
    output logic [scds_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    output logic                              o_m_axis_tlast
);

    import scds_pkg::*;

    logic [SIZE_W-1:0]         r_grid;
    logic [SIZE_W-1:0]         n_eff;
    logic [COL_W-1:0]          r_row, r_col;
    logic                      r_sk_v, r_sk_user;
    logic [DATA_W-1:0]         r_sk_data;
    logic                      in_fire, entering, en;
    logic [DATA_W-1:0]         src_data;
    logic                      src_user;
    logic [COL_W-1:0]          row_cur, col_cur, rr;
    logic [SIZE_W-1:0]         row_p1, col_p1;
    logic                      has_main, has_final, col_wrap, interior;
    logic [LANES-1:0]          ram_we;
    logic [LANES*DATA_W-1:0]   rd_a, rd_b;
    logic [LANES*DATA_W-1:0]   r_hb1, r_hb2, r_ha1;
    logic                      r_s1_v;
    t_ctx                      r_s1;
    t_ctx                      ctx0;
    logic [1:0]                s0, s1, s2, s3;
    logic [SUM_W-1:0]          sum_d, sum_x;
    logic                      r_v [SQ_STEPS+1];
    t_ctx                      r_ctx [SQ_STEPS+1];
    t_sq                       r_sqd [SQ_STEPS+1];
    t_sq                       r_sqx [SQ_STEPS+1];
    logic [30:0]               r_offs_x;
    logic [62:0]               r_offs_p;
    logic [OFFS_W-1:0]         offs;
    logic [SQ_STEPS:0]         root_sum;
    logic [29:0]               tenx;
    logic [32:0]               total;
    logic [DATA_W-1:0]         fin_val;
    logic                      r_tail_v;
    t_ctx                      r_tail;
    logic [DATA_W-1:0]         r_tail_val;
    logic [1:0]                r_sel;
    logic [1:0]                cnt, res_idx;
    logic                      last, tail_done;
    t_res                      kind;
    logic [COL_W-1:0]          o_row, o_col;
    logic [DATA_W-1:0]         o_val;

    function automatic logic [DATA_W-1:0] lane(logic [LANES*DATA_W-1:0] w, logic [1:0] k);
        return w[k*DATA_W +: DATA_W];
    endfunction

    // one bit of a restoring square root
    function automatic t_sq sq_step(t_sq s);
        logic [REM_W-1:0] rem_n;
        logic [REM_W-1:0] trial;
        t_sq              o;
        rem_n = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
        trial = {s.root[SQ_STEPS-1:0], 2'b01};
        o.rad = {s.rad[RAD_W-3:0], 2'b00};
        if (rem_n >= trial) begin
            o.rem  = rem_n - trial;
            o.root = {s.root[SQ_STEPS-2:0], 1'b1};
        end else begin
            o.rem  = rem_n;
            o.root = {s.root[SQ_STEPS-2:0], 1'b0};
        end
        return o;
    endfunction

    // size register and clamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid <= RST_SIZE;
        end else if (i_cfg_wr_en) begin
            r_grid <= i_cfg_wr_data;
        end
    end

    assign n_eff = (r_grid < MIN_SIZE) ? MIN_SIZE : ((r_grid > MAX_SIZE) ? MAX_SIZE : r_grid);

    // additive offset, two registered steps
    always_ff @(posedge i_clk) begin
        r_offs_x <= {n_eff, 17'b0} + OFFS_ROUND;
        r_offs_p <= 63'(r_offs_x) * 63'(OFFS_RECIP);
    end

    assign offs = r_offs_p[61:38];

    // input skid and entry
    assign o_s_axis_tready = !r_sk_v;
    assign in_fire  = i_s_axis_tvalid && !r_sk_v;
    assign entering = en && (r_sk_v || in_fire);
    assign src_data = r_sk_v ? r_sk_data : i_s_axis_tdata;
    assign src_user = r_sk_v ? r_sk_user : i_s_axis_tuser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_v <= 1'b0;
        end else if (!r_sk_v) begin
            if (in_fire && !en) begin
                r_sk_v <= 1'b1;
            end
        end else if (en) begin
            r_sk_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && !en) begin
            r_sk_data <= i_s_axis_tdata;
            r_sk_user <= i_s_axis_tuser;
        end
    end

    // position of the entering item
    assign row_cur   = src_user ? '0 : r_row;
    assign col_cur   = src_user ? '0 : r_col;
    assign row_p1    = {1'b0, row_cur} + 14'd1;
    assign col_p1    = {1'b0, col_cur} + 14'd1;
    assign has_main  = row_cur >= 13'd2;
    assign has_final = row_p1 >= n_eff;
    assign col_wrap  = col_p1 >= n_eff;
    assign rr        = row_cur - 13'd2;
    assign interior  = has_main && (rr >= 13'd2) && (({1'b0, rr} + 14'd2) < n_eff)
                    && (col_cur >= 13'd2) && (({1'b0, col_cur} + 14'd2) < n_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (entering) begin
            if (col_wrap) begin
                r_col <= '0;
                r_row <= has_final ? '0 : row_p1[COL_W-1:0];
            end else begin
                r_col <= col_p1[COL_W-1:0];
                r_row <= row_cur;
            end
        end
    end

    // line store, lane = row mod 4
    assign ram_we = entering ? (LANES'(1) << row_cur[1:0]) : '0;

    scds_ram #(
        .LANE_W (DATA_W),
        .LANES  (LANES),
        .DEPTH  (MAX_COLS)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (col_cur),
        .i_wdata   (src_data),
        .i_re      (entering),
        .i_raddr_a (col_cur + 13'd2),
        .i_raddr_b (col_cur),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // stage 1 context
    always_ff @(posedge i_clk) begin
        if (entering) begin
            r_s1.row       <= row_cur;
            r_s1.col       <= col_cur;
            r_s1.has_main  <= has_main;
            r_s1.has_final <= has_final;
            r_s1.interior  <= interior;
            r_s1.v         <= src_data;
            r_s1.pass      <= '0;
            r_s1.prev      <= '0;
        end
    end

    // column history of earlier reads in this row
    always_ff @(posedge i_clk) begin
        if (en && r_s1_v) begin
            r_hb1 <= rd_b;
            r_hb2 <= r_hb1;
            r_ha1 <= rd_a;
        end
    end

    // neighbor sums: s0 row r-4, s1 row r-3, s2 row r-2, s3 row r-1
    assign s0 = r_s1.row[1:0];
    assign s1 = r_s1.row[1:0] + 2'd1;
    assign s2 = r_s1.row[1:0] + 2'd2;
    assign s3 = r_s1.row[1:0] + 2'd3;

    assign sum_d = SUM_W'(lane(r_hb1, s1)) + SUM_W'(lane(r_ha1, s1))
                 + SUM_W'(lane(r_hb1, s3)) + SUM_W'(lane(r_ha1, s3));
    assign sum_x = SUM_W'(lane(r_hb2, s2)) + SUM_W'(lane(rd_a, s2))
                 + SUM_W'(lane(rd_b, s0)) + SUM_W'(r_s1.v);

    always_comb begin
        ctx0      = r_s1;
        ctx0.pass = lane(rd_b, s2);
        ctx0.prev = lane(rd_b, s3);
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_tail_v <= 1'b0;
            for (int k = 0; k <= SQ_STEPS; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_s1_v   <= entering;
            r_v[0]   <= r_s1_v;
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_v[k+1] <= r_v[k];
            end
            r_tail_v <= r_v[SQ_STEPS];
        end
    end

    // square root stages, one result bit per stage
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctx[0]      <= ctx0;
            r_sqd[0].rad  <= {sum_d, 16'b0};
            r_sqd[0].rem  <= '0;
            r_sqd[0].root <= '0;
            r_sqx[0].rad  <= {sum_x, 16'b0};
            r_sqx[0].rem  <= '0;
            r_sqx[0].root <= '0;
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_ctx[k+1] <= r_ctx[k];
                r_sqd[k+1] <= sq_step(r_sqd[k]);
                r_sqx[k+1] <= sq_step(r_sqx[k]);
            end
        end
    end

    // offset + 10 * (root_d + root_x), saturated; non-interior items take the pass value
    assign root_sum = {1'b0, r_sqd[SQ_STEPS].root} + {1'b0, r_sqx[SQ_STEPS].root};
    assign tenx     = {1'b0, root_sum, 3'b000} + {3'b000, root_sum, 1'b0};
    assign total    = {3'b000, tenx} + 33'(offs);
    assign fin_val  = !r_ctx[SQ_STEPS].interior ? r_ctx[SQ_STEPS].pass
                    : (total[32] ? '1 : total[DATA_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tail     <= r_ctx[SQ_STEPS];
            r_tail_val <= fin_val;
        end
    end

    // output serializer over the results of the tail item
    assign cnt       = {1'b0, r_tail.has_main} + {r_tail.has_final, 1'b0};
    assign res_idx   = r_tail.has_main ? r_sel : r_sel + 2'd1;
    assign kind      = t_res'(res_idx);
    assign last      = r_sel == (cnt - 2'd1);
    assign tail_done = r_tail_v && ((cnt == 2'd0) || (i_m_axis_tready && last));
    assign en        = !r_tail_v || tail_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= '0;
        end else if (tail_done) begin
            r_sel <= '0;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            r_sel <= r_sel + 2'd1;
        end
    end

    always_comb begin
        unique case (kind)
            RES_MAIN: begin
                o_row = r_tail.row - 13'd2;
                o_col = r_tail.col;
                o_val = r_tail_val;
            end
            RES_PREV: begin
                o_row = r_tail.row - 13'd1;
                o_col = r_tail.col;
                o_val = r_tail.prev;
            end
            RES_CUR: begin
                o_row = r_tail.row;
                o_col = r_tail.col;
                o_val = r_tail.v;
            end
            default: begin
                o_row = '0;
                o_col = '0;
                o_val = '0;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_tail_v && (cnt != 2'd0);
    assign o_m_axis_tlast  = last;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - OUT_USED_W)'(0), o_val, o_col, o_row};

endmodule

// ===== hw/rtl/scds_checker.sv =====
module scds_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_s_axis_tready,
    input  logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic [scds_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input  logic                              o_m_axis_tlast
);

    import scds_pkg::*;

`include "sqrt_cross_diag_stencil_core_macros.svh"

    // stalled output transaction holds
    `SCDS_AST_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)
    `SCDS_AST_NEXT(a_out_stable, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))

    // padding above the packed fields stays zero
    `SCDS_AST_NOW(a_out_pad, o_m_axis_tvalid, o_m_axis_tdata[OUT_TDATA_W-1:OUT_USED_W] == '0)

    // reset empties the pipeline and the skid stage
    `SCDS_AST_RST(a_rst_out, !o_m_axis_tvalid)
    `SCDS_AST_RST(a_rst_in, o_s_axis_tready)

endmodule

bind sqrt_cross_diag_stencil_core scds_checker u_scds_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ===== sim/sqrt_cross_diag_stencil_core_tb.sv =====
`timescale 1ns / 1ps

module sqrt_cross_diag_stencil_core_tb;
    import scds_pkg::*;

    localparam int WATCH_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 60;
    localparam int LONG_HOLD   = 400;

    typedef struct packed {
        logic [COL_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              last;
    } t_cell_res;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [SIZE_W-1:0]      i_cfg_wr_data = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   i_s_axis_tuser = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tlast;

    // predictor state
    logic [DATA_W-1:0] grid_rows [0:4*MAX_COLS-1];
    int unsigned       cur_row, cur_col, size_reg;
    t_cell_res         pending_cells [$];
    int                err_cnt = 0;
    int                idle_cycles = 0;
    int                hold_cycles = 0;
    bit                hold_req = 1'b0;

    sqrt_cross_diag_stencil_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] cell_at(int unsigned r, int unsigned c);
        return grid_rows[(r & 3) * MAX_COLS + (c % MAX_COLS)];
    endfunction

    function automatic int unsigned grid_n();
        if (size_reg < 5) return 5;
        if (size_reg > MAX_COLS) return MAX_COLS;
        return size_reg;
    endfunction

    // expected results for one accepted cell
    task automatic predict_cell(logic [DATA_W-1:0] v, logic fs);
        int unsigned n, r, c, rr;
        longint unsigned dsum, xsum, offs, t;
        t_cell_res res;
        int first_idx;
        n = grid_n();
        if (fs) begin
            cur_row = 0;
            cur_col = 0;
        end
        r = cur_row;
        c = cur_col;
        first_idx = pending_cells.size();
        if (r >= 2) begin
            rr = r - 2;
            res.row = rr[COL_W-1:0];
            res.col = c[COL_W-1:0];
            res.last = 1'b0;
            if (rr >= 2 && rr + 2 < n && c >= 2 && c + 2 < n) begin
                dsum = 64'(cell_at(rr-1, c-1)) + cell_at(rr-1, c+1)
                     + cell_at(rr+1, c-1) + cell_at(rr+1, c+1);
                xsum = 64'(cell_at(rr, c-2)) + cell_at(rr, c+2) + cell_at(rr-2, c) + v;
                offs = (64'(n) * 131072 + 50) / 100;
                t = offs + 10 * (int_sqrt(dsum << 16) + int_sqrt(xsum << 16));
                res.value = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
            end else begin
                res.value = cell_at(rr, c);
            end
            pending_cells.push_back(res);
        end
        grid_rows[(r & 3) * MAX_COLS + (c % MAX_COLS)] = v;
        if (r + 1 >= n) begin
            res.row = 13'(r - 1);
            res.col = c[COL_W-1:0];
            res.value = cell_at(r - 1, c);
            res.last = 1'b0;
            pending_cells.push_back(res);
            res.row = r[COL_W-1:0];
            res.value = v;
            pending_cells.push_back(res);
        end
        if (pending_cells.size() > first_idx)
            pending_cells[pending_cells.size()-1].last = 1'b1;
        if (c + 1 >= n) begin
            cur_col = 0;
            cur_row = (r + 1 >= n) ? 0 : r + 1;
        end else begin
            cur_col = c + 1;
        end
    endtask

    function automatic int unsigned gap_len();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k < 6) return 0;
        if (k < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [DATA_W-1:0] rand_cell();
        case ($urandom_range(0, 3))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 32'h0003_FFFF);
            default: return $urandom;
        endcase
    endfunction

    // send one cell, idle gap first when asked
    task automatic send_cell(logic [DATA_W-1:0] v, logic fs, int unsigned gap);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= v;
        i_s_axis_tuser  <= fs;
        forever begin
            @(negedge i_clk);
            if (o_s_axis_tready) break;
        end
        @(posedge i_clk);
        predict_cell(v, fs);
    endtask

    // wait for all results, then let the pipeline settle
    task automatic drain();
        @(posedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] sz);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= sz;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        size_reg = sz;
    endtask

    // clamped maximum size: a short run in the first row, no results due
    task automatic test_large_grid();
        write_size(14'h3FFF);
        for (int i = 0; i < 16; i++)
            send_cell(rand_cell(), (i == 0), gap_len());
        drain();
    endtask

    // smallest grid, extremes and a restart mid-row
    task automatic test_small_directed();
        write_size(14'd0);
        for (int i = 0; i < 25; i++)
            send_cell((i % 2) ? 32'hFFFF_FFFF : 32'h0, (i == 0), gap_len());
        for (int i = 0; i < 3; i++) send_cell(32'hA5A5_5A5A, (i == 0), 0);
        for (int i = 0; i < 25; i++) send_cell(32'hFFFF_FFFF, (i == 0), gap_len());
        drain();
    endtask

    // random frames across sizes, with frame restarts as noise
    task automatic test_random_frames(int unsigned items);
        int unsigned sent;
        int unsigned n;
        sent = 0;
        while (sent < items) begin
            case ($urandom_range(0, 3))
                0: n = 5;
                1: n = 12;
                default: n = $urandom_range(5, 12);
            endcase
            write_size(n[SIZE_W-1:0]);
            for (int i = 0; i < n * n; i++) begin
                send_cell(rand_cell(), (i == 0) || ($urandom_range(0, 99) < 2), gap_len());
                sent++;
            end
            drain();
        end
    endtask

    // receiver holds off while the sender keeps pushing
    task automatic test_backpressure();
        write_size(14'd6);
        hold_req = 1'b1;
        for (int i = 0; i < 72; i++) send_cell(rand_cell(), (i == 0), 0);
        drain();
        write_size(RST_SIZE);
    endtask

    // sink ready with random stalls and one long hold
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req    <= 1'b0;
            hold_cycles <= LONG_HOLD;
            i_m_axis_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 39) == 0) begin
            hold_cycles <= $urandom_range(10, 40);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // result check on each output transaction
    always @(negedge i_clk) begin
        t_cell_res got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.row   = o_m_axis_tdata[12:0];
            got.col   = o_m_axis_tdata[25:13];
            got.value = o_m_axis_tdata[57:26];
            got.last  = o_m_axis_tlast;
            if (pending_cells.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result row %0d col %0d value %h",
                             got.row, got.col, got.value);
            end else begin
                want = pending_cells.pop_front();
                if (got !== want || o_m_axis_tdata[63:58] !== 6'd0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch exp r%0d c%0d v%h l%0d got r%0d c%0d v%h l%0d",
                                 want.row, want.col, want.value, want.last,
                                 got.row, got.col, got.value, got.last);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(negedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        cur_row = 0;
        cur_col = 0;
        size_reg = RST_SIZE;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_large_grid();
        test_small_directed();
        test_backpressure();
        test_random_frames(40);
        drain();
        if (err_cnt == 0 && pending_cells.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
